@@ rtl/ras_pkg.sv @@
// ----------------------------------------------------------------------------
// ras_pkg
// Shared widths, register indexes, op codes and sequencer states of the ring
// all-reduce schedule generator.
// ----------------------------------------------------------------------------
package ras_pkg;

	localparam int unsigned RAS_MAX_RANKS = 64;

	localparam int unsigned RC_W      = 7;
	localparam int unsigned OWN_W     = 6;
	localparam int unsigned BYTES_W   = 40;
	localparam int unsigned EB_W      = 4;
	localparam int unsigned STEP_W    = 6;
	localparam int unsigned IDX_W     = 8;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned PEER_W    = 6;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [RC_W-1:0]  RC_RESET  = 7'd2;
	localparam logic [OWN_W-1:0] OWN_RESET = 6'd0;
	localparam logic [EB_W-1:0]  EB_RESET  = 4'd4;

	localparam logic [CFG_IDX_W-1:0] REG_RANK_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OWN_RANK      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 2'd3;

	typedef enum logic [KIND_W-1:0] {
		OP_SEND        = 2'd0,
		OP_RECV_REDUCE = 2'd1,
		OP_RECV        = 2'd2
	} op_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_ELEM,
		ST_DIV_RANK,
		ST_DIV_OWN,
		ST_OWNER,
		ST_SEND_MUL,
		ST_SEND_OUT,
		ST_RECV_MUL,
		ST_RECV_OUT
	} state_t;

endpackage

@@ rtl/ras_in_if.sv @@
// ----------------------------------------------------------------------------
// ras_in_if
// Step channel: one ring step per transfer.
// ----------------------------------------------------------------------------
interface ras_in_if;
	import ras_pkg::*;

	logic              valid;
	logic              ready;
	logic              new_plan;
	logic              phase;
	logic [STEP_W-1:0] ring_step;

	modport source (output valid, output new_plan, output phase, output ring_step,
		input ready);
	modport sink (input valid, input new_plan, input phase, input ring_step,
		output ready);

endinterface

@@ rtl/ras_out_if.sv @@
// ----------------------------------------------------------------------------
// ras_out_if
// Op channel: one planned send or receive per transfer.
// ----------------------------------------------------------------------------
interface ras_out_if;
	import ras_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  op_kind;
	logic [IDX_W-1:0]   op_index;
	logic [BYTES_W-1:0] shard_bytes;
	logic [BYTES_W-1:0] shard_offset;
	logic [PEER_W-1:0]  peer_rank;
	logic               has_dependency;
	logic [IDX_W-1:0]   dependency_index;
	logic               last_of_run;

	modport source (output valid, output op_kind, output op_index, output shard_bytes,
		output shard_offset, output peer_rank, output has_dependency,
		output dependency_index, output last_of_run, input ready);
	modport sink (input valid, input op_kind, input op_index, input shard_bytes,
		input shard_offset, input peer_rank, input has_dependency,
		input dependency_index, input last_of_run, output ready);

endinterface

@@ rtl/ras_ram.sv @@
// ----------------------------------------------------------------------------
// ras_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ras_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/ras_div.sv @@
// ----------------------------------------------------------------------------
// ras_div
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ras_div #(
	parameter int unsigned DW = 40,
	parameter int unsigned VW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
);

	localparam int unsigned CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [VW:0]   shifted;
	logic [VW:0]   diff;
	logic          fits;

	assign shifted   = {rem_q, quo_q[DW-1]};
	assign diff      = shifted - {1'b0, dvs_q};
	assign fits      = !diff[VW];
	assign busy      = (cnt_q != '0);
	assign quotient  = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CW'(DW);
		end else if (busy) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : shifted[VW-1:0];
		end
	end

endmodule

@@ rtl/ring_allreduce_schedule.sv @@
// ----------------------------------------------------------------------------
// ring_allreduce_schedule
// Ring all-reduce op planner for one rank: per ring step, a send to the next
// rank and a receive from the previous one, over balanced shards.
// ----------------------------------------------------------------------------
// Each accepted step, while the shard geometry is current, runs through accept,
// owner resolution, then a multiply state and an issue state for the send and
// again for the receive; an issue state holds while the previous op is still
// waiting on the output register. The first step after any register write also
// recomputes the geometry through the shared bit-serial divider, three divisions
// (elements, shard base and remainder, own rank modulo the ring size). The step
// channel is ready only between steps; the last op of a step may still wait at
// the output. A step whose index plus one reaches the ring size issues no op.
// ----------------------------------------------------------------------------
module ring_allreduce_schedule #(
	parameter int unsigned MAX_RANKS = ras_pkg::RAS_MAX_RANKS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ras_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ras_pkg::BYTES_W-1:0]     cfg_wdata,
	ras_in_if.sink                          step_in,
	ras_out_if.source                       op_out
);
	import ras_pkg::*;

	localparam int unsigned NW = $clog2(MAX_RANKS + 1);
	localparam int unsigned RW = $clog2(MAX_RANKS);
	localparam int unsigned VW = (NW > EB_W) ? NW : EB_W;
	localparam int unsigned MW = (RW > EB_W) ? RW : EB_W;
	localparam int unsigned TW = NW + 1;

	logic [RC_W-1:0]    rank_count_q;
	logic [OWN_W-1:0]   own_rank_q;
	logic [BYTES_W-1:0] buf_bytes_q;
	logic [EB_W-1:0]    elem_bytes_q;
	logic [NW-1:0]      n_eff;
	logic [EB_W-1:0]    eb_eff;
	logic               geom_dirty_q;

	state_t state_q, state_d;

	logic               phase_q;
	logic [STEP_W-1:0]  step_q;
	logic [BYTES_W-1:0] base_q;
	logic [RW-1:0]      extra_q;
	logic [RW-1:0]      r_q;
	logic [BYTES_W-1:0] sz_lo_q;
	logic [RW-1:0]      send_own_q;
	logic [RW-1:0]      recv_own_q;
	logic [IDX_W-1:0]   op_cnt_q;
	logic [MAX_RANKS-1:0] vld_q;

	logic               accept;
	logic               div_load;
	logic [BYTES_W-1:0] div_dvd;
	logic [VW-1:0]      div_dvs;
	logic               div_busy;
	logic [BYTES_W-1:0] div_quo;
	logic [VW-1:0]      div_rem;
	logic               cap_base;
	logic               cap_r;
	logic               cap_owner;
	logic               load_send;
	logic               load_recv;
	logic               load_out;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_rdata;

	logic [BYTES_W-1:0]      mul_a;
	logic [MW-1:0]           mul_b;
	logic [BYTES_W+MW-1:0]   mul_full;
	logic [BYTES_W-1:0]      mul_prod_q;
	logic [RW-1:0]           sml_min;
	logic [RW+EB_W-1:0]      sml_full;
	logic [RW+EB_W-1:0]      sml_prod_q;

	logic [RW-1:0]      nm1;
	logic [TW-1:0]      t_sum;
	logic [RW-1:0]      send0;
	logic [RW-1:0]      send1;
	logic [RW-1:0]      recv0;
	logic               late;
	logic [RW-1:0]      next_rank;
	logic [RW-1:0]      prev_rank;
	logic [RW-1:0]      send_min;
	logic [RW-1:0]      recv_min;
	logic [BYTES_W-1:0] send_size;
	logic [BYTES_W-1:0] recv_size;
	logic [BYTES_W-1:0] cur_off;
	logic               send_nz;
	logic               recv_nz;
	logic               slot_free;

	logic               out_valid_q;
	op_kind_t           o_kind_q;
	logic [IDX_W-1:0]   o_index_q;
	logic [BYTES_W-1:0] o_bytes_q;
	logic [BYTES_W-1:0] o_off_q;
	logic [PEER_W-1:0]  o_peer_q;
	logic               o_dep_q;
	logic [IDX_W-1:0]   o_dep_idx_q;
	logic               o_last_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_count_q <= RC_RESET;
			own_rank_q   <= OWN_RESET;
			buf_bytes_q  <= '0;
			elem_bytes_q <= EB_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_RANK_COUNT:    rank_count_q <= cfg_wdata[RC_W-1:0];
				REG_OWN_RANK:      own_rank_q   <= cfg_wdata[OWN_W-1:0];
				REG_BUFFER_BYTES:  buf_bytes_q  <= cfg_wdata;
				REG_ELEMENT_BYTES: elem_bytes_q <= cfg_wdata[EB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (rank_count_q < RC_W'(2)) begin
			n_eff = NW'(2);
		end else if (32'(rank_count_q) > MAX_RANKS) begin
			n_eff = NW'(MAX_RANKS);
		end else begin
			n_eff = NW'(rank_count_q);
		end
	end

	assign eb_eff = (elem_bytes_q == '0) ? EB_W'(1) : elem_bytes_q;

	// shared divider
	ras_div #(
		.DW(BYTES_W),
		.VW(VW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (div_load),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// last-receive index table
	ras_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_RANKS)
	) u_idx_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (recv_own_q),
		.wdata (op_cnt_q),
		.raddr (send_own_q),
		.rdata (ram_rdata)
	);

	// owner resolution
	assign nm1       = RW'(n_eff - NW'(1));
	assign t_sum     = TW'(r_q) + TW'(n_eff) - TW'(step_q);
	assign send0     = (t_sum >= TW'(n_eff)) ? RW'(t_sum - TW'(n_eff)) : RW'(t_sum);
	assign send1     = (send0 == nm1) ? '0 : send0 + RW'(1);
	assign recv0     = (send0 == '0) ? nm1 : send0 - RW'(1);
	assign late      = (32'(step_q) + 32'd1) >= 32'(n_eff);
	assign next_rank = (r_q == nm1) ? '0 : r_q + RW'(1);
	assign prev_rank = (r_q == '0) ? nm1 : r_q - RW'(1);

	// shard geometry
	assign send_min  = (send_own_q < extra_q) ? send_own_q : extra_q;
	assign recv_min  = (recv_own_q < extra_q) ? recv_own_q : extra_q;
	assign send_size = (send_own_q < extra_q) ? sz_lo_q + BYTES_W'(eb_eff) : sz_lo_q;
	assign recv_size = (recv_own_q < extra_q) ? sz_lo_q + BYTES_W'(eb_eff) : sz_lo_q;
	assign cur_off   = mul_prod_q + BYTES_W'(sml_prod_q);
	assign send_nz   = (send_size != '0);
	assign recv_nz   = (sz_lo_q != '0) || (recv_own_q < extra_q);
	assign slot_free = !out_valid_q || op_out.ready;

	assign mul_full = {{MW{1'b0}}, mul_a} * {{BYTES_W{1'b0}}, mul_b};
	assign sml_full = {{EB_W{1'b0}}, sml_min} * {{RW{1'b0}}, eb_eff};

	always_ff @(posedge clk) begin
		mul_prod_q <= mul_full[BYTES_W-1:0];
		sml_prod_q <= sml_full;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = geom_dirty_q ? ST_DIV_ELEM : ST_OWNER;
				end
			end
			ST_DIV_ELEM: begin
				if (!div_busy) begin
					state_d = ST_DIV_RANK;
				end
			end
			ST_DIV_RANK: begin
				if (!div_busy) begin
					state_d = ST_DIV_OWN;
				end
			end
			ST_DIV_OWN: begin
				if (!div_busy) begin
					state_d = ST_OWNER;
				end
			end
			ST_OWNER:    state_d = late ? ST_IDLE : ST_SEND_MUL;
			ST_SEND_MUL: state_d = ST_SEND_OUT;
			ST_SEND_OUT: begin
				if (!send_nz || slot_free) begin
					state_d = ST_RECV_MUL;
				end
			end
			ST_RECV_MUL: state_d = ST_RECV_OUT;
			ST_RECV_OUT: begin
				if (!recv_nz || slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		accept    = 1'b0;
		div_load  = 1'b0;
		div_dvd   = buf_bytes_q;
		div_dvs   = VW'(eb_eff);
		cap_base  = 1'b0;
		cap_r     = 1'b0;
		cap_owner = 1'b0;
		load_send = 1'b0;
		load_recv = 1'b0;
		ram_we    = 1'b0;
		mul_a     = base_q;
		mul_b     = MW'(eb_eff);
		sml_min   = send_min;
		case (state_q)
			ST_IDLE: begin
				accept   = step_in.valid;
				div_load = step_in.valid && geom_dirty_q;
			end
			ST_DIV_ELEM: begin
				div_load = !div_busy;
				div_dvd  = div_quo;
				div_dvs  = VW'(n_eff);
			end
			ST_DIV_RANK: begin
				div_load = !div_busy;
				cap_base = !div_busy;
				div_dvd  = BYTES_W'(own_rank_q);
				div_dvs  = VW'(n_eff);
			end
			ST_DIV_OWN: begin
				cap_r = !div_busy;
			end
			ST_OWNER: begin
				cap_owner = 1'b1;
			end
			ST_SEND_MUL, ST_SEND_OUT: begin
				mul_a     = sz_lo_q;
				mul_b     = MW'(send_own_q);
				sml_min   = send_min;
				load_send = (state_q == ST_SEND_OUT) && send_nz && slot_free;
			end
			ST_RECV_MUL, ST_RECV_OUT: begin
				mul_a     = sz_lo_q;
				mul_b     = MW'(recv_own_q);
				sml_min   = recv_min;
				load_recv = (state_q == ST_RECV_OUT) && recv_nz && slot_free;
				ram_we    = load_recv;
			end
			default: ;
		endcase
	end

	assign load_out      = load_send || load_recv;
	assign step_in.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			geom_dirty_q <= 1'b1;
			op_cnt_q     <= '0;
			vld_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				geom_dirty_q <= 1'b1;
			end else if (cap_r) begin
				geom_dirty_q <= 1'b0;
			end
			if (accept && step_in.new_plan) begin
				op_cnt_q <= '0;
				vld_q    <= '0;
			end else begin
				if (load_out) begin
					op_cnt_q <= op_cnt_q + IDX_W'(1);
				end
				if (ram_we) begin
					vld_q[recv_own_q] <= 1'b1;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (op_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			phase_q <= step_in.phase;
			step_q  <= step_in.ring_step;
		end
		if (cap_base) begin
			base_q  <= div_quo;
			extra_q <= RW'(div_rem);
		end
		if (cap_r) begin
			r_q <= RW'(div_rem);
		end
		if (cap_owner) begin
			sz_lo_q    <= mul_prod_q;
			send_own_q <= phase_q ? send1 : send0;
			recv_own_q <= phase_q ? send0 : recv0;
		end
		if (load_send) begin
			o_kind_q    <= OP_SEND;
			o_index_q   <= op_cnt_q;
			o_bytes_q   <= send_size;
			o_off_q     <= cur_off;
			o_peer_q    <= PEER_W'(next_rank);
			o_dep_q     <= vld_q[send_own_q];
			o_dep_idx_q <= vld_q[send_own_q] ? ram_rdata : '0;
			o_last_q    <= !recv_nz;
		end else if (load_recv) begin
			o_kind_q    <= phase_q ? OP_RECV : OP_RECV_REDUCE;
			o_index_q   <= op_cnt_q;
			o_bytes_q   <= recv_size;
			o_off_q     <= cur_off;
			o_peer_q    <= PEER_W'(prev_rank);
			o_dep_q     <= 1'b0;
			o_dep_idx_q <= '0;
			o_last_q    <= 1'b1;
		end
	end

	assign op_out.valid            = out_valid_q;
	assign op_out.op_kind          = o_kind_q;
	assign op_out.op_index         = o_index_q;
	assign op_out.shard_bytes      = o_bytes_q;
	assign op_out.shard_offset     = o_off_q;
	assign op_out.peer_rank        = o_peer_q;
	assign op_out.has_dependency   = o_dep_q;
	assign op_out.dependency_index = o_dep_idx_q;
	assign op_out.last_of_run      = o_last_q;

`ifndef SYNTHESIS
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		step_in.valid && step_in.ready |=> !step_in.ready)
		else $error("step channel ready straight after a transfer");

	a_div_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_load |-> !div_busy)
		else $error("divider loaded while busy");

	a_counter_advance: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> op_cnt_q == IDX_W'($past(op_cnt_q) + IDX_W'(1)))
		else $error("op counter did not advance with an issued op");

	a_table_mark: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> vld_q[$past(recv_own_q)])
		else $error("recorded receive not marked valid");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		op_out.valid && !op_out.ready |-> !load_out)
		else $error("pending op overwritten");
`endif

endmodule
